// ----- hw/rtl/fifo_queue_with_delete_macros.svh -----
// ----------------------------------------------------------------------------
// fifo_queue_with_delete_macros.svh
// Assertion macros used by the queue checker.
// ----------------------------------------------------------------------------
`ifndef FIFO_QUEUE_WITH_DELETE_MACROS_SVH
`define FIFO_QUEUE_WITH_DELETE_MACROS_SVH

// Checked at every rising edge outside reset.
`define FQD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define FQD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- hw/rtl/fqd_pkg.sv -----
// ----------------------------------------------------------------------------
// fqd_pkg
// Types and constants of the queue with delete-by-value.
// ----------------------------------------------------------------------------
package fqd_pkg;

    localparam int CAPACITY_DEF   = 16;
    localparam int VALUE_BITS_DEF = 32;

    localparam int OPCODE_W = 2;
    localparam int ITEM_W   = 32;
    localparam int COUNT_W  = 5;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ENQ = 2'd0,
        OP_DEQ = 2'd1,
        OP_DEL = 2'd2
    } t_opcode;

    localparam logic ST_OK     = 1'b0;
    localparam logic ST_REJECT = 1'b1;

    // Per-cell control from the queue controller
    typedef struct packed {
        logic occ;   // cell holds an entry
        logic load;  // cell is the tail slot of an accepted enqueue
        logic deq;   // accepted dequeue: every cell takes its neighbor
        logic del;   // delete of a nonzero key: cells at and after a hit take their neighbor
    } t_cell_ctl;

endpackage

// ----- hw/rtl/fqd_if.sv -----
// ----------------------------------------------------------------------------
// fqd_if
// Command and response channels of the queue, valid/ready handshake.
// ----------------------------------------------------------------------------
interface fqd_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [fqd_pkg::OPCODE_W-1:0]  opcode;
    logic [fqd_pkg::ITEM_W-1:0]    item_value;

    modport source (output valid, output opcode, output item_value, input ready);
    modport sink   (input valid, input opcode, input item_value, output ready);
endinterface

interface fqd_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          status;
    logic [fqd_pkg::ITEM_W-1:0]    out_value;
    logic [fqd_pkg::COUNT_W-1:0]   entry_count;

    modport source (output valid, output status, output out_value, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input out_value, input entry_count,
                    output ready);
endinterface

// ----- hw/rtl/fifo_queue_with_delete.sv -----
// ----------------------------------------------------------------------------
// fifo_queue_with_delete
// Bounded FIFO of nonzero handles with enqueue, dequeue and delete-first-match.
// ----------------------------------------------------------------------------
// Each command beat is one operation and yields exactly one response beat in the
// cycle after it is accepted; a new command is taken every cycle as long as the
// response register is empty or being drained. Entries sit in a row of
// CAPACITY cells with the head in cell 0. Dequeue shifts every cell up by one;
// delete shifts the cells from the first match on, so order is kept. The
// clock period is set by the match chain that ripples through all cells
// (one VALUE_BITS compare per cell, then an OR per cell). Zero handles, enqueue
// when full, dequeue when empty, delete without a match and the unused opcode
// are rejected with status 1, out_value 0 and the count unchanged.
// ----------------------------------------------------------------------------
module fifo_queue_with_delete #(
    parameter int CAPACITY   = fqd_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS = fqd_pkg::VALUE_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fqd_cmd_if.sink    i_cmd,
    fqd_rsp_if.source  o_rsp
);
    import fqd_pkg::*;

    localparam int CNT_NEED = $clog2(CAPACITY + 1);
    localparam int CNT_W    = (CNT_NEED > COUNT_W) ? CNT_NEED : COUNT_W;

    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic                  r_out_valid;
    logic                  n_out_valid;
    logic                  r_status;
    logic                  n_status;
    logic [ITEM_W-1:0]     r_out_value;
    logic [ITEM_W-1:0]     n_out_value;

    logic                  fire;
    logic [VALUE_BITS-1:0] key;
    logic [VALUE_BITS-1:0] head;
    logic [ITEM_W-1:0]     head_out;
    logic                  key_nz;
    logic                  any_hit;
    logic                  do_enq;
    logic                  do_deq;
    logic                  do_del;

    logic [VALUE_BITS-1:0] cell_value [CAPACITY];
    logic [CAPACITY:0]     hit;
    t_cell_ctl             cell_ctl  [CAPACITY];

    // no beat is taken while reset is held
    assign i_cmd.ready = i_rst_n && (!r_out_valid || o_rsp.ready);
    assign fire        = i_cmd.valid && i_cmd.ready;

    // value width adaptation between the 32-bit fields and the stored width
    generate
        if (VALUE_BITS > ITEM_W) begin : g_wide
            assign key      = {{(VALUE_BITS-ITEM_W){1'b0}}, i_cmd.item_value};
            assign head_out = head[ITEM_W-1:0];
        end else if (VALUE_BITS == ITEM_W) begin : g_same
            assign key      = i_cmd.item_value;
            assign head_out = head;
        end else begin : g_narrow
            assign key      = i_cmd.item_value[VALUE_BITS-1:0];
            assign head_out = {{(ITEM_W-VALUE_BITS){1'b0}}, head};
        end
    endgenerate

    assign head    = cell_value[0];
    assign key_nz  = (key != '0);
    assign hit[0]  = 1'b0;
    assign any_hit = hit[CAPACITY];

    always_comb begin
        do_enq = 1'b0;
        do_deq = 1'b0;
        do_del = 1'b0;
        case (t_opcode'(i_cmd.opcode))
            OP_ENQ:  do_enq = fire && key_nz && (r_count != CNT_W'(CAPACITY));
            OP_DEQ:  do_deq = fire && (r_count != '0);
            OP_DEL:  do_del = fire && key_nz;
            default: ;
        endcase
    end

    generate
        for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic [VALUE_BITS-1:0] next_value;

            if (gi == CAPACITY - 1) begin : g_last
                assign next_value = '0;
            end else begin : g_mid
                assign next_value = cell_value[gi+1];
            end

            assign cell_ctl[gi].occ  = (CNT_W'(gi) < r_count);
            assign cell_ctl[gi].load = do_enq && (r_count == CNT_W'(gi));
            assign cell_ctl[gi].deq  = do_deq;
            assign cell_ctl[gi].del  = do_del;

            fqd_cell #(
                .VALUE_BITS (VALUE_BITS)
            ) u_cell (
                .i_clk        (i_clk),
                .i_ctl        (cell_ctl[gi]),
                .i_key        (key),
                .i_next_value (next_value),
                .i_hit_in     (hit[gi]),
                .o_value      (cell_value[gi]),
                .o_hit_out    (hit[gi+1])
            );
        end
    endgenerate

    always_comb begin
        n_count     = r_count;
        n_status    = ST_REJECT;
        n_out_value = '0;
        if (do_enq) begin
            n_count  = r_count + CNT_W'(1);
            n_status = ST_OK;
        end else if (do_deq) begin
            n_count     = r_count - CNT_W'(1);
            n_status    = ST_OK;
            n_out_value = head_out;
        end else if (do_del && any_hit) begin
            n_count  = r_count - CNT_W'(1);
            n_status = ST_OK;
        end
    end

    always_comb begin
        if (fire) begin
            n_out_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // response payload; count is the value after the operation
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_status    <= n_status;
            r_out_value <= n_out_value;
        end
    end

    logic [COUNT_W-1:0] r_count_out;

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_count_out <= n_count[COUNT_W-1:0];
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_status;
    assign o_rsp.out_value   = r_out_value;
    assign o_rsp.entry_count = r_count_out;

endmodule

// ----- hw/rtl/fqd_cell.sv -----
// ----------------------------------------------------------------------------
// fqd_cell
// One queue slot: holds a value, compares it against the key and either keeps
// it, takes the neighbor's value (compaction) or loads the key (enqueue).
// ----------------------------------------------------------------------------
module fqd_cell #(
    parameter int VALUE_BITS = fqd_pkg::VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  fqd_pkg::t_cell_ctl    i_ctl,
    input  logic [VALUE_BITS-1:0] i_key,
    input  logic [VALUE_BITS-1:0] i_next_value,
    input  logic                  i_hit_in,
    output logic [VALUE_BITS-1:0] o_value,
    output logic                  o_hit_out
);
    logic [VALUE_BITS-1:0] r_value;
    logic [VALUE_BITS-1:0] n_value;

    // hit propagates toward the tail: set once the first match is seen
    assign o_hit_out = i_hit_in | (i_ctl.occ && (r_value == i_key));
    assign o_value   = r_value;

    always_comb begin
        n_value = r_value;
        if (i_ctl.load) begin
            n_value = i_key;
        end else if (i_ctl.deq || (i_ctl.del && o_hit_out)) begin
            n_value = i_next_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

// ----- hw/rtl/fqd_checker.sv -----
// ----------------------------------------------------------------------------
// fqd_checker
// Port-level checks of the queue response channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "fifo_queue_with_delete_macros.svh"

module fqd_checker #(
    parameter int CAPACITY = fqd_pkg::CAPACITY_DEF
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_cmd_valid,
    input logic                         i_cmd_ready,
    input logic                         i_rsp_valid,
    input logic                         i_rsp_ready,
    input logic                         i_rsp_status,
    input logic [fqd_pkg::ITEM_W-1:0]   i_rsp_out_value,
    input logic [fqd_pkg::COUNT_W-1:0]  i_rsp_entry_count
);
    import fqd_pkg::*;

    // a rejected beat never carries a value
    `FQD_ASSERT(a_reject_no_value, i_rsp_valid && (i_rsp_status == ST_REJECT) |-> i_rsp_out_value == '0, "rejected beat with nonzero value")

    // count never exceeds the capacity (when it fits the field)
    `FQD_ASSERT(a_count_bound, i_rsp_valid |-> (CAPACITY > 31) || (int'(i_rsp_entry_count) <= CAPACITY), "entry count above capacity")

    // every accepted command yields a response beat on the next cycle
    `FQD_ASSERT(a_cmd_to_rsp, i_cmd_valid && i_cmd_ready |=> i_rsp_valid, "accepted command without response")

    // a stalled response holds its payload
    `FQD_ASSERT(a_rsp_hold, i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_status) && $stable(i_rsp_out_value) && $stable(i_rsp_entry_count), "stalled response changed")

    // nothing is presented right after reset
    `FQD_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> !i_rsp_valid, "response valid after reset")

endmodule

bind fifo_queue_with_delete fqd_checker #(
    .CAPACITY (CAPACITY)
) u_fqd_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_cmd_valid       (i_cmd.valid),
    .i_cmd_ready       (i_cmd.ready),
    .i_rsp_valid       (o_rsp.valid),
    .i_rsp_ready       (o_rsp.ready),
    .i_rsp_status      (o_rsp.status),
    .i_rsp_out_value   (o_rsp.out_value),
    .i_rsp_entry_count (o_rsp.entry_count)
);
